// ----- rtl/itaf_pkg.sv -----
// shared types, character codes and decimal step table for the integer formatter
package itaf_pkg;

  localparam logic [1:0] CMD_HEX   = 2'd0;
  localparam logic [1:0] CMD_UDEC  = 2'd1;
  localparam logic [1:0] CMD_SDEC  = 2'd2;
  localparam logic [1:0] CMD_UNDEF = 2'd3;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_A_LOW = 8'h61;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [3:0] DIGIT_TEN   = 4'hA;

  localparam int VALUE_W  = 32;
  localparam int STEP_W   = 34;
  localparam int DEC_POS  = 10;
  localparam int HEX_POS  = 8;
  localparam int POS_W    = 4;

  typedef logic [DEC_POS-1:0][DEC_POS-1:0][STEP_W-1:0] dec_tab_t;

  // one queued item after classification
  typedef struct packed {
    logic               hex;
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } itaf_item_t;

  // entry [k][d] holds d times ten to the power k
  function automatic dec_tab_t build_dec_tab();
    dec_tab_t          tab;
    logic [STEP_W-1:0] p;
    p = STEP_W'(1);
    for (int k = 0; k < DEC_POS; k++) begin
      for (int d = 0; d < DEC_POS; d++) begin
        tab[k][d] = STEP_W'(p * STEP_W'(d));
      end
      p = STEP_W'(p * STEP_W'(10));
    end
    return tab;
  endfunction

  localparam dec_tab_t DEC_STEP = build_dec_tab();

endpackage

// ----- rtl/itaf_in_if.sv -----
// input channel: format command and value
interface itaf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] value;

  modport source (output valid, command, value, input ready);
  modport sink (input valid, command, value, output ready);
endinterface

// ----- rtl/itaf_out_if.sv -----
// output channel: one character and its end-of-text flag
interface itaf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, character, last, input ready);
  modport sink (input valid, character, last, output ready);
endinterface

// ----- rtl/itaf_front.sv -----
// front end: accepts items, drops undefined formats, forms sign and magnitude
module itaf_front (
  itaf_in_if.sink               request,
  input  logic                  full,
  output logic                  push,
  output itaf_pkg::itaf_item_t  item
);

  logic is_neg;

  assign request.ready = !full;
  assign is_neg = (request.command == itaf_pkg::CMD_SDEC) && request.value[31];
  assign push = request.valid && !full && (request.command != itaf_pkg::CMD_UNDEF);

  always_comb begin
    item.hex = (request.command == itaf_pkg::CMD_HEX);
    item.neg = is_neg;
    item.mag = is_neg ? (32'd0 - request.value) : request.value;
  end

endmodule

// ----- rtl/itaf_queue.sv -----
// two-entry queue between front end and character engine
module itaf_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  itaf_pkg::itaf_item_t  push_item,
  output logic                  full,
  output logic                  head_valid,
  output itaf_pkg::itaf_item_t  head_item,
  input  logic                  pop
);

  itaf_pkg::itaf_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/itaf_back.sv -----
// character engine: emits one character per cycle unless the response stalls, most significant first
module itaf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  itaf_pkg::itaf_item_t  head_item,
  output logic                  pop,
  itaf_out_if.source            response
);

  logic                               busy;
  logic                               neg;
  logic                               hex;
  logic [itaf_pkg::VALUE_W-1:0]       mag;
  logic [itaf_pkg::POS_W-1:0]         pos;
  logic                               out_valid;
  logic [7:0]                         out_char;
  logic                               out_last;

  logic                               adv;
  logic                               step;
  logic                               fin;
  logic [3:0]                         nibble;
  logic [3:0]                         digit;
  logic [itaf_pkg::STEP_W-1:0]        wide_mag;
  logic [itaf_pkg::VALUE_W-1:0]       mag_next;
  logic [7:0]                         emit_char;
  logic [itaf_pkg::POS_W-1:0]         start_pos;
  logic [itaf_pkg::STEP_W-1:0]        head_wide;

  assign response.valid     = out_valid;
  assign response.character = out_char;
  assign response.last      = out_last;

  assign adv  = !out_valid || response.ready;
  assign step = busy && adv;
  assign fin  = step && !neg && (pos == '0);
  assign pop  = head_valid && (!busy || fin);

  assign wide_mag = {2'b00, mag};
  assign nibble   = 4'(mag >> {pos[2:0], 2'b00});

  // decimal digit at the current position
  always_comb begin
    digit = 4'd0;
    for (int d = 1; d < itaf_pkg::DEC_POS; d++) begin
      if (wide_mag >= itaf_pkg::DEC_STEP[pos][d]) begin
        digit = 4'(d);
      end
    end
    mag_next = itaf_pkg::VALUE_W'(wide_mag - itaf_pkg::DEC_STEP[pos][digit]);
  end

  always_comb begin
    if (neg) begin
      emit_char = itaf_pkg::ASCII_MINUS;
    end else if (hex) begin
      if (nibble < itaf_pkg::DIGIT_TEN) begin
        emit_char = 8'(itaf_pkg::ASCII_ZERO + {4'b0000, nibble});
      end else begin
        emit_char = 8'(itaf_pkg::ASCII_A_LOW + {4'b0000, nibble}
                       - {4'b0000, itaf_pkg::DIGIT_TEN});
      end
    end else begin
      emit_char = 8'(itaf_pkg::ASCII_ZERO + {4'b0000, digit});
    end
  end

  // position of the leading digit of the next item
  assign head_wide = {2'b00, head_item.mag};
  always_comb begin
    start_pos = '0;
    if (head_item.hex) begin
      for (int i = 1; i < itaf_pkg::HEX_POS; i++) begin
        if (head_item.mag[i*4 +: 4] != 4'd0) begin
          start_pos = itaf_pkg::POS_W'(i);
        end
      end
    end else begin
      for (int k = 1; k < itaf_pkg::DEC_POS; k++) begin
        if (head_wide >= itaf_pkg::DEC_STEP[k][1]) begin
          start_pos = itaf_pkg::POS_W'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      neg       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
        neg  <= head_item.neg;
      end else begin
        if (fin) begin
          busy <= 1'b0;
        end
        if (step && neg) begin
          neg <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_char <= emit_char;
      out_last <= !neg && (pos == '0);
    end
    if (pop) begin
      hex <= head_item.hex;
      mag <= head_item.mag;
      pos <= start_pos;
    end else if (step && !neg) begin
      pos <= pos - itaf_pkg::POS_W'(1);
      if (!hex) begin
        mag <= mag_next;
      end
    end
  end

endmodule

// ----- rtl/integer_to_ascii_formatter.sv -----
// top level of the integer to ascii text formatter
// usage:
//   request carries a 2-bit format command (hex, unsigned decimal, signed
//   decimal) and a 32-bit value; a transaction takes place when valid and
//   ready are both high. command 3 is taken and produces nothing.
//   response carries one ascii character per transaction, most significant
//   first, with last set on the final character of each value's text.
//   the front end classifies each item into a two-entry queue; the character
//   engine behind it emits one character per cycle unless the response
//   stalls, so an item occupies the engine until its text is out: 1 to 8
//   characters for hex, 1 to 10 for unsigned, 1 to 11 for signed decimal.
//   consecutive items follow each other with no gap on the response side.
//   when the engine is idle, the first character passes from the queue
//   through the engine's item registers into the output register.
//   a stalled response holds its character in the output register; the
//   engine waits, the queue fills and request ready drops once it is full.
//   synchronous reset empties the queue and the output register.
module integer_to_ascii_formatter (
  input logic        clk,
  input logic        rst,
  itaf_in_if.sink    request,
  itaf_out_if.source response
);

  logic                 full;
  logic                 push;
  itaf_pkg::itaf_item_t push_item;
  logic                 head_valid;
  itaf_pkg::itaf_item_t head_item;
  logic                 pop;

  itaf_front u_front (
    .request (request),
    .full    (full),
    .push    (push),
    .item    (push_item)
  );

  itaf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  itaf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .response   (response)
  );

endmodule

// ----- tb/itaf_text_checker.sv -----
// checker for the integer formatter: predicts each value's text and compares characters
`timescale 1ns / 100ps

module itaf_text_checker (
  input  logic clk,
  input  logic rst,
  itaf_in_if   request,
  itaf_out_if  response,
  output int   failures,
  output int   pending
);

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  text_char_t text_queue[$];

  function automatic void format_text(input logic [1:0] command, input logic [31:0] value);
    logic [31:0] mag;
    logic [31:0] base;
    logic [31:0] digit;
    logic [7:0]  digits[$];
    text_char_t  entry;
    case (command)
      itaf_pkg::CMD_HEX: begin
        base = 32'd16;
        mag  = value;
      end
      itaf_pkg::CMD_UDEC: begin
        base = 32'd10;
        mag  = value;
      end
      itaf_pkg::CMD_SDEC: begin
        base = 32'd10;
        mag  = value;
        if (value[31]) begin
          // magnitude in unsigned arithmetic, so the most negative value stays exact
          mag = 32'd0 - value;
          entry.character = itaf_pkg::ASCII_MINUS;
          entry.last      = 1'b0;
          text_queue.push_back(entry);
        end
      end
      default: return;
    endcase
    if (mag == 32'd0) begin
      digits.push_front(itaf_pkg::ASCII_ZERO);
    end
    while (mag != 32'd0) begin
      digit = mag % base;
      if (digit < 32'd10) begin
        digits.push_front(itaf_pkg::ASCII_ZERO + 8'(digit));
      end else begin
        digits.push_front(itaf_pkg::ASCII_A_LOW + 8'(digit) - 8'(itaf_pkg::DIGIT_TEN));
      end
      mag = mag / base;
    end
    foreach (digits[i]) begin
      entry.character = digits[i];
      entry.last      = (i == digits.size() - 1);
      text_queue.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (request.valid && request.ready) begin
        format_text(request.command, request.value);
      end
      if (response.valid && response.ready) begin
        if (text_queue.size() == 0) begin
          $error("unexpected character %h (last %b)", response.character, response.last);
          failures = failures + 1;
        end else begin
          want = text_queue.pop_front();
          if (response.character !== want.character) begin
            $error("character mismatch: expected %h, got %h", want.character,
                   response.character);
            failures = failures + 1;
          end
          if (response.last !== want.last) begin
            $error("last mismatch: expected %b, got %b", want.last, response.last);
            failures = failures + 1;
          end
        end
      end
    end
    pending = text_queue.size();
  end

endmodule

// ----- tb/integer_to_ascii_formatter_test.sv -----
// top of the integer formatter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module integer_to_ascii_formatter_test;

  localparam int  RANDOM_ITEMS = 300;
  localparam int  CYCLE_LIMIT  = 200000;
  localparam int  DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  logic steady;
  int   failures;
  int   pending;
  int   cycles;
  int   sent;

  itaf_in_if  request ();
  itaf_out_if response ();

  integer_to_ascii_formatter dut (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .response (response)
  );

  itaf_text_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .response (response),
    .failures (failures),
    .pending  (pending)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    response.ready <= steady || ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_item(input logic [1:0] command, input logic [31:0] value);
    while (!steady && $urandom_range(99) < 16) begin
      request.valid <= 1'b0;
      @(negedge clk);
    end
    request.valid   <= 1'b1;
    request.command <= command;
    request.value   <= value;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] pow;
    pow = 32'd1;
    case ($urandom_range(5))
      0: return 32'($urandom_range(20));
      1: return 32'h7fff_fffe + 32'($urandom_range(3));
      2: return 32'hffff_ffff - 32'($urandom_range(20));
      3: begin
        repeat ($urandom_range(9)) pow = pow * 32'd10;
        return pow + 32'($urandom_range(2)) - 32'd1;
      end
      4: return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_command();
    if ($urandom_range(99) < 4) begin
      return itaf_pkg::CMD_UNDEF;
    end
    case ($urandom_range(2))
      0: return itaf_pkg::CMD_HEX;
      1: return itaf_pkg::CMD_UDEC;
      default: return itaf_pkg::CMD_SDEC;
    endcase
  endfunction

  initial begin
    logic [1:0] command;
    clk             = 1'b0;
    rst             = 1'b1;
    steady          = 1'b0;
    cycles          = 0;
    sent            = 0;
    request.valid   = 1'b0;
    request.command = itaf_pkg::CMD_HEX;
    request.value   = 32'd0;
    response.ready  = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero in every format, extremes, sign boundary, all hex letters, undefined command
    send_item(itaf_pkg::CMD_HEX,   32'd0);
    send_item(itaf_pkg::CMD_UDEC,  32'd0);
    send_item(itaf_pkg::CMD_SDEC,  32'd0);
    send_item(itaf_pkg::CMD_HEX,   32'hffff_ffff);
    send_item(itaf_pkg::CMD_UDEC,  32'hffff_ffff);
    send_item(itaf_pkg::CMD_SDEC,  32'hffff_ffff);
    send_item(itaf_pkg::CMD_SDEC,  32'h8000_0000);
    send_item(itaf_pkg::CMD_SDEC,  32'h7fff_ffff);
    send_item(itaf_pkg::CMD_HEX,   32'h8000_0000);
    send_item(itaf_pkg::CMD_UDEC,  32'h8000_0000);
    send_item(itaf_pkg::CMD_HEX,   32'hfedc_ba98);
    send_item(itaf_pkg::CMD_HEX,   32'h0123_4567);
    send_item(itaf_pkg::CMD_UDEC,  32'd1000000000);
    send_item(itaf_pkg::CMD_UDEC,  32'd999999999);
    send_item(itaf_pkg::CMD_SDEC,  32'hc465_3600);
    send_item(itaf_pkg::CMD_HEX,   32'd1);
    send_item(itaf_pkg::CMD_UDEC,  32'd9);
    send_item(itaf_pkg::CMD_UDEC,  32'd10);
    send_item(itaf_pkg::CMD_HEX,   32'd15);
    send_item(itaf_pkg::CMD_HEX,   32'd16);
    send_item(itaf_pkg::CMD_UNDEF, 32'h5a5a_a5a5);
    send_item(itaf_pkg::CMD_UNDEF, 32'd0);
    send_item(itaf_pkg::CMD_SDEC,  32'd1);

    while (sent < RANDOM_ITEMS) begin
      steady  = (sent >= 120 && sent < 200);
      command = pick_command();
      send_item(command, pick_value());
      if (command != itaf_pkg::CMD_UNDEF) begin
        sent++;
      end
    end
    steady = 1'b0;
    request.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
